// File: sv/tnm_pkg.sv
// Shared types, constants and amplitude functions for the three-tone noise mixer.
`default_nettype none

package tnm_pkg;

  // Channel counts and field widths.
  localparam int unsigned NUM_TONES   = 3;
  localparam int unsigned RATE_W      = 17;
  localparam int unsigned FREQ_W      = 21;
  localparam int unsigned LEVEL_W     = 4;
  localparam int unsigned AMP_W       = 13;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 21;
  localparam int unsigned DIFF_W      = 22;
  localparam int unsigned DIV_STEPS   = FREQ_W;
  localparam int unsigned DIV_CNT_W   = 5;

  // Amplitude constants.
  localparam int unsigned TONE_STEP   = 500;
  localparam int unsigned NOISE_START = 8;

  // Reset value of the half sample rate register.
  localparam logic [RATE_W-1:0] HALF_RATE_RST = RATE_W'(22050);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE0_FREQ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE1_FREQ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE2_FREQ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE0_LEVEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE1_LEVEL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE2_LEVEL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEVEL = 3'd7;

  // Configuration register contents.
  typedef struct packed {
    logic [RATE_W-1:0]                    half_rate;
    logic [NUM_TONES-1:0][FREQ_W-1:0]     freq;
    logic [NUM_TONES-1:0][LEVEL_W-1:0]    level;
    logic [LEVEL_W-1:0]                   noise_level;
  } tnm_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;   // transaction accepted: form the sample sum
    logic       prep;    // subtract the frequency of channel ch
    logic       step;    // one restoring division step
    logic       finish;  // write back accumulator and polarity of channel ch
    logic       push;    // move the held sum into the output register
    logic [1:0] ch;
  } tnm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic neg;           // accumulator went negative after the subtraction
  } tnm_status_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_PUSH
  } tnm_state_e;

  // Tone amplitude: level times the step.
  function automatic logic [AMP_W-1:0] tone_amp(input logic [LEVEL_W-1:0] level);
    tone_amp = AMP_W'(level) * AMP_W'(TONE_STEP);
  endfunction

  // Noise amplitude: silent below the start level, then rising by one step.
  function automatic logic [AMP_W-1:0] noise_amp(input logic [LEVEL_W-1:0] level);
    logic [LEVEL_W-1:0] offs;
    offs = level - LEVEL_W'(NOISE_START - 1);
    if (level < LEVEL_W'(NOISE_START)) begin
      noise_amp = '0;
    end else begin
      noise_amp = AMP_W'(offs) * AMP_W'(TONE_STEP);
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/tnm_cfg_regs.sv
// Configuration register file of the three-tone noise mixer.
`default_nettype none

module tnm_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tnm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tnm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output tnm_pkg::tnm_cfg_t                   cfg_o
);
  import tnm_pkg::*;

  tnm_cfg_t cfg_q;
  tnm_cfg_t cfg_d;

  // Decode a write into the addressed register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HALF_RATE:   cfg_d.half_rate   = cfg_wdata_i[RATE_W-1:0];
        CFG_TONE0_FREQ:  cfg_d.freq[0]     = cfg_wdata_i[FREQ_W-1:0];
        CFG_TONE1_FREQ:  cfg_d.freq[1]     = cfg_wdata_i[FREQ_W-1:0];
        CFG_TONE2_FREQ:  cfg_d.freq[2]     = cfg_wdata_i[FREQ_W-1:0];
        CFG_TONE0_LEVEL: cfg_d.level[0]    = cfg_wdata_i[LEVEL_W-1:0];
        CFG_TONE1_LEVEL: cfg_d.level[1]    = cfg_wdata_i[LEVEL_W-1:0];
        CFG_TONE2_LEVEL: cfg_d.level[2]    = cfg_wdata_i[LEVEL_W-1:0];
        CFG_NOISE_LEVEL: cfg_d.noise_level = cfg_wdata_i[LEVEL_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // Register storage with reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{half_rate: HALF_RATE_RST, freq: '0, level: '0, noise_level: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/tnm_ctrl.sv
// Controller state machine that sequences the tone channel updates.
`default_nettype none

module tnm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire tnm_pkg::tnm_status_t status_i,
  output tnm_pkg::tnm_cmd_t         cmd_o
);
  import tnm_pkg::*;

  tnm_state_e           state_q, state_d;
  logic [1:0]           ch_q, ch_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;
  logic                 last_ch;

  assign out_free = !out_valid_q || !out_stall_i;
  assign last_ch  = (ch_q == 2'(NUM_TONES - 1));

  // State register, channel and step counters, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    cmd_o.ch    = ch_q;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          ch_d        = '0;
          state_d     = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        if (status_i.neg) begin
          cnt_d   = '0;
          state_d = ST_DIV;
        end else if (last_ch) begin
          state_d = ST_PUSH;
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        if (last_ch) begin
          state_d = ST_PUSH;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = ST_PREP;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: sv/tnm_datapath.sv
// Datapath: sample mixing, tone accumulators and the shared flip-count divider.
`default_nettype none

module tnm_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire tnm_pkg::tnm_cfg_t              cfg_i,
  input  wire tnm_pkg::tnm_cmd_t              cmd_i,
  output tnm_pkg::tnm_status_t                status_o,
  input  wire logic                           resync_i,
  input  wire logic                           timer_out0_i,
  input  wire logic                           timer_out1_i,
  input  wire logic                           timer_out2_i,
  input  wire logic                           noise_bit_i,
  output logic signed [tnm_pkg::SAMPLE_W-1:0] mixed_sample_o
);
  import tnm_pkg::*;

  // Tone state: accumulators never go negative and fit in the rate width.
  logic [NUM_TONES-1:0][RATE_W-1:0] acc_q, acc_d;
  logic [NUM_TONES-1:0]             pos_q, pos_d;

  // Division state and held sample.
  logic [FREQ_W-1:0]          dvd_q, dvd_d;
  logic [RATE_W-1:0]          rem_q, rem_d;
  logic                       qbit_q, qbit_d;
  logic signed [SAMPLE_W-1:0] sum_q, sum_d;
  logic signed [SAMPLE_W-1:0] out_q, out_d;

  logic [RATE_W-1:0]          rate;
  logic [RATE_W-1:0]          acc_sel;
  logic [FREQ_W-1:0]          freq_sel;
  logic [DIFF_W-1:0]          diff;
  logic [FREQ_W-1:0]          deficit;
  logic [RATE_W:0]            trial;
  logic                       rem_nz;
  logic [NUM_TONES-1:0]       timer;
  logic [NUM_TONES-1:0]       pol;
  logic signed [SAMPLE_W-1:0] mix;

  // A zero half rate counts as one.
  assign rate  = (cfg_i.half_rate == '0) ? RATE_W'(1) : cfg_i.half_rate;
  assign timer = {timer_out2_i, timer_out1_i, timer_out0_i};

  // Select the channel being updated.
  always_comb begin
    case (cmd_i.ch)
      2'd0:    begin acc_sel = acc_q[0]; freq_sel = cfg_i.freq[0]; end
      2'd1:    begin acc_sel = acc_q[1]; freq_sel = cfg_i.freq[1]; end
      default: begin acc_sel = acc_q[2]; freq_sel = cfg_i.freq[2]; end
    endcase
  end

  // Accumulator minus frequency; a negative result needs flips.
  assign diff          = DIFF_W'(acc_sel) - DIFF_W'(freq_sel);
  assign deficit       = FREQ_W'(DIFF_W'(0) - diff);
  assign status_o.neg  = diff[DIFF_W-1];

  // One restoring division step on the deficit.
  assign trial  = {rem_q, dvd_q[FREQ_W-1]};
  assign rem_nz = (rem_q != '0);

  // Mix with polarities before this tick's advance (timer outputs on resync).
  always_comb begin
    pol = resync_i ? timer : pos_q;
    mix = '0;
    for (int i = 0; i < NUM_TONES; i++) begin
      if (pol[i]) begin
        mix = mix + $signed(SAMPLE_W'(tone_amp(cfg_i.level[i])));
      end else begin
        mix = mix - $signed(SAMPLE_W'(tone_amp(cfg_i.level[i])));
      end
    end
    if (noise_bit_i) begin
      mix = mix + $signed(SAMPLE_W'(noise_amp(cfg_i.noise_level)));
    end else begin
      mix = mix - $signed(SAMPLE_W'(noise_amp(cfg_i.noise_level)));
    end
  end

  // Next values of the datapath registers.
  always_comb begin
    acc_d  = acc_q;
    pos_d  = pos_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    qbit_d = qbit_q;
    sum_d  = sum_q;
    out_d  = out_q;

    if (cmd_i.start) begin
      pos_d = pol;
      sum_d = mix;
    end

    if (cmd_i.prep) begin
      if (diff[DIFF_W-1]) begin
        dvd_d  = deficit;
        rem_d  = '0;
        qbit_d = 1'b0;
      end else begin
        acc_d[cmd_i.ch] = diff[RATE_W-1:0];
      end
    end

    if (cmd_i.step) begin
      dvd_d = {dvd_q[FREQ_W-2:0], 1'b0};
      if (trial >= {1'b0, rate}) begin
        rem_d  = RATE_W'(trial - {1'b0, rate});
        qbit_d = 1'b1;
      end else begin
        rem_d  = trial[RATE_W-1:0];
        qbit_d = 1'b0;
      end
    end

    // Smallest flip count n = ceil(deficit / rate); new value rate*n - deficit.
    if (cmd_i.finish) begin
      acc_d[cmd_i.ch] = rem_nz ? (rate - rem_q) : '0;
      if (qbit_q ^ rem_nz) begin
        pos_d[cmd_i.ch] = !pos_q[cmd_i.ch];
      end
    end

    if (cmd_i.push) begin
      out_d = sum_q;
    end
  end

  // Tone state needs a reset; the rest is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= '0;
    end else begin
      acc_q <= acc_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    qbit_q <= qbit_d;
    sum_q  <= sum_d;
    out_q  <= out_d;
  end

  assign mixed_sample_o = out_q;

endmodule

`default_nettype wire

// File: sv/three_tone_noise_sound_mixer_core.sv
// Once a transaction is accepted, each tone channel in turn takes a prep step,
// plus division steps and a finish step when its accumulator goes negative,
// on the shared one-bit-per-cycle divider (21 steps) that counts the flips.
// Then the sample is pushed once the output is free; then a new one is accepted.
// Reset clears accumulators and polarities (negative) and loads register
// defaults; there is no clearing pass.
`default_nettype none

module three_tone_noise_sound_mixer_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tnm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tnm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           resync_i,
  input  wire logic                           timer_out0_i,
  input  wire logic                           timer_out1_i,
  input  wire logic                           timer_out2_i,
  input  wire logic                           noise_bit_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [tnm_pkg::SAMPLE_W-1:0] mixed_sample_o
);
  import tnm_pkg::*;

  tnm_cfg_t    cfg;
  tnm_cmd_t    cmd;
  tnm_status_t status;

  // Configuration registers.
  tnm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequencer.
  tnm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Mixing and tone update datapath.
  tnm_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .status_o       (status),
    .resync_i       (resync_i),
    .timer_out0_i   (timer_out0_i),
    .timer_out1_i   (timer_out1_i),
    .timer_out2_i   (timer_out2_i),
    .noise_bit_i    (noise_bit_i),
    .mixed_sample_o (mixed_sample_o)
  );

endmodule

`default_nettype wire
